[rtl/iwm_pkg.sv]
`timescale 1ns / 1ps

package iwm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DIFF_W      = SAMPLE_BITS + 1;   // window span, signed
  localparam int SUM_W       = SAMPLE_BITS + 4;   // mode sum, signed
  localparam int NUM_W       = SUM_W + 9;         // scaled numerator, signed
  localparam int DEN_W       = DIFF_W + 2;        // signed denominator, up to 4 * span
  localparam int MAG_W       = DEN_W - 1;         // denominator magnitude
  localparam int REM_W       = NUM_W;             // divider remainder, unsigned
  localparam int FOLD_SHIFT  = 9;                 // 512 = 1 << FOLD_SHIFT
  localparam int QUOT_BITS   = FOLD_SHIFT + 1;    // quotient bits, top two flag overflow
  localparam int LEVEL_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int IN_DATA_W   = ((3 * SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [1:0] VIEW_DIRECT   = 2'd0;
  localparam logic [1:0] VIEW_INVERTED = 2'd1;
  localparam logic [1:0] VIEW_DIFF     = 2'd2;
  localparam logic [1:0] VIEW_BLEND    = 2'd3;

  localparam logic [1:0] POL_ZERO = 2'd0;
  localparam logic [1:0] POL_FULL = 2'd1;
  localparam logic [1:0] POL_FOLD = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_VIEW_MODE    = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_ABOVE_POLICY = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_BELOW_POLICY = CFG_INDEX_W'(4);

  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LEVEL_MID  = LEVEL_W'(128);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = LEVEL_W'(255);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] window_low;
    logic signed [SAMPLE_BITS-1:0] window_high;
    logic [1:0]                    view_mode;
    logic [1:0]                    above_policy;
    logic [1:0]                    below_policy;
  } cfg_t;

  // result already settled ahead of the divider
  typedef struct packed {
    logic               forced;
    logic [LEVEL_W-1:0] level;
    logic               empty;
  } side_t;

endpackage

[rtl/iwm_front.sv]
`timescale 1ns / 1ps

module iwm_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  iwm_pkg::cfg_t                           cfg,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [iwm_pkg::SAMPLE_BITS-1:0]  center,
  input  logic signed [iwm_pkg::SAMPLE_BITS-1:0]  prior,
  input  logic signed [iwm_pkg::SAMPLE_BITS-1:0]  following,
  input  logic                                    present,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [iwm_pkg::NUM_W-1:0]        out_nn,
  output logic [iwm_pkg::MAG_W-1:0]               out_dd,
  output iwm_pkg::side_t                          out_side
);
  import iwm_pkg::*;

  logic                     v1, blend1, diff1;
  logic signed [SUM_W-1:0]  s1;
  logic signed [DIFF_W-1:0] d1;
  side_t                    side1;
  logic                     ready1, ready2;

  logic signed [SUM_W-1:0]  c_x, p_x, f_x, lo_x, hi_x, s_next;
  logic signed [DIFF_W-1:0] d_next;
  side_t                    side_next;

  logic signed [NUM_W-1:0]  n_x, nn_next;
  logic signed [DEN_W-1:0]  den_x, den_abs;
  logic                     neg;

  assign ready2   = !out_valid || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_comb begin
    c_x    = SUM_W'(center);
    p_x    = SUM_W'(prior);
    f_x    = SUM_W'(following);
    lo_x   = SUM_W'(cfg.window_low);
    hi_x   = SUM_W'(cfg.window_high);
    d_next = DIFF_W'(cfg.window_high) - DIFF_W'(cfg.window_low);
    case (cfg.view_mode)
      VIEW_DIRECT:   s_next = c_x - lo_x;
      VIEW_INVERTED: s_next = hi_x - c_x;
      VIEW_DIFF:     s_next = c_x - p_x;
      default:       s_next = p_x + (c_x <<< 1) + f_x - (lo_x <<< 2);
    endcase
    side_next.empty  = (d_next == '0);
    side_next.forced = side_next.empty || (cfg.view_mode == VIEW_DIFF && !present);
    side_next.level  = side_next.empty ? LEVEL_ZERO : LEVEL_MID;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
    if (ready1 && in_valid) begin
      s1     <= s_next;
      d1     <= d_next;
      blend1 <= (cfg.view_mode == VIEW_BLEND);
      diff1  <= (cfg.view_mode == VIEW_DIFF);
      side1  <= side_next;
    end
  end

  // times 255 as shift minus one, difference mode adds 128 spans
  always_comb begin
    n_x = (NUM_W'(s1) <<< 8) - NUM_W'(s1)
          + (diff1 ? (NUM_W'(d1) <<< 7) : NUM_W'(0));
    den_x   = blend1 ? (DEN_W'(d1) <<< 2) : DEN_W'(d1);
    neg     = den_x[DEN_W-1];
    nn_next = neg ? -n_x : n_x;
    den_abs = neg ? -den_x : den_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
    if (ready2 && v1) begin
      out_nn   <= nn_next;
      out_dd   <= den_abs[MAG_W-1:0];
      out_side <= side1;
    end
  end

endmodule

[rtl/iwm_classify.sv]
`timescale 1ns / 1ps

module iwm_classify (
  input  logic                              clk,
  input  logic                              rst,
  input  iwm_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [iwm_pkg::NUM_W-1:0]  in_nn,
  input  logic [iwm_pkg::MAG_W-1:0]         in_dd,
  input  iwm_pkg::side_t                    in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [iwm_pkg::REM_W-1:0]         out_rem,
  output logic [iwm_pkg::REM_W-1:0]         out_div,
  output iwm_pkg::side_t                    out_side
);
  import iwm_pkg::*;

  logic                    v3, above3, below3;
  logic signed [NUM_W-1:0] nn3;
  logic [MAG_W-1:0]        dd3;
  side_t                   side3;
  logic                    ready3, ready4;

  logic [MAG_W+7:0]        top_x;
  logic                    above_next;

  logic signed [NUM_W-1:0] fold_x, neg_nn, m_x;
  side_t                   side_next;

  assign ready4   = !out_valid || out_ready;
  assign ready3   = !v3 || ready4;
  assign in_ready = ready3;

  always_comb begin
    top_x      = {in_dd, 8'd0} - {8'd0, in_dd};
    above_next = in_nn > $signed(NUM_W'(top_x));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= in_valid;
    end
    if (ready3 && in_valid) begin
      above3 <= above_next;
      below3 <= in_nn[NUM_W-1];
      nn3    <= in_nn;
      dd3    <= in_dd;
      side3  <= in_side;
    end
  end

  always_comb begin
    fold_x    = $signed(NUM_W'({dd3, {FOLD_SHIFT{1'b0}}})) - nn3;
    neg_nn    = -nn3;
    m_x       = nn3;
    side_next = side3;
    if (!side3.forced) begin
      if (above3) begin
        case (cfg.above_policy)
          POL_ZERO: begin
            side_next.forced = 1'b1;
            side_next.level  = LEVEL_ZERO;
          end
          POL_FOLD: begin
            m_x = fold_x;
            if (fold_x <= 0) begin
              side_next.forced = 1'b1;
              side_next.level  = LEVEL_ZERO;
            end
          end
          default: begin
            side_next.forced = 1'b1;
            side_next.level  = LEVEL_MAX;
          end
        endcase
      end else if (below3) begin
        case (cfg.below_policy)
          POL_FULL: begin
            side_next.forced = 1'b1;
            side_next.level  = LEVEL_MAX;
          end
          POL_FOLD: m_x = neg_nn;
          default: begin
            side_next.forced = 1'b1;
            side_next.level  = LEVEL_ZERO;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready4) begin
      out_valid <= v3;
    end
    if (ready4 && v3) begin
      out_rem  <= REM_W'(m_x);
      out_div  <= REM_W'({dd3, {FOLD_SHIFT{1'b0}}});
      out_side <= side_next;
    end
  end

endmodule

[rtl/iwm_cell.sv]
`timescale 1ns / 1ps

module iwm_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [iwm_pkg::REM_W-1:0]        in_rem,
  input  logic [iwm_pkg::REM_W-1:0]        in_div,
  input  logic [iwm_pkg::QUOT_BITS-1:0]    in_quot,
  input  iwm_pkg::side_t                   in_side,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [iwm_pkg::REM_W-1:0]        out_rem,
  output logic [iwm_pkg::REM_W-1:0]        out_div,
  output logic [iwm_pkg::QUOT_BITS-1:0]    out_quot,
  output iwm_pkg::side_t                   out_side
);
  import iwm_pkg::*;

  logic ge;

  assign in_ready = !out_valid || out_ready;
  assign ge       = (in_rem >= in_div);

  // one restoring step, divisor handed on already aligned for the next bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_rem  <= ge ? (in_rem - in_div) : in_rem;
      out_div  <= in_div >> 1;
      out_quot <= {in_quot[QUOT_BITS-2:0], ge};
      out_side <= in_side;
    end
  end

endmodule

[rtl/intensity_window_mapper_unit.sv]
`timescale 1ns / 1ps
// registers from input transaction to result: front 2, classify 2,
//   one divider cell per quotient bit 10, output register 1
// throughput: one item per cycle while m_tready does not stall, set by the pipelined restoring divider cells
// reset: synchronous, clears every valid flag and loads the default window
//   0..255, direct view, saturating above and zeroing below

module intensity_window_mapper_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // center_sample, prior_sample, following_sample
  input  logic [iwm_pkg::IN_DATA_W-1:0]          s_tdata,
  // prior_present
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // display_level
  output logic [iwm_pkg::LEVEL_W-1:0]            m_tdata,
  // window_empty
  output logic                                   m_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [iwm_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [iwm_pkg::SAMPLE_BITS-1:0]        cfg_data
);
  import iwm_pkg::*;

  cfg_t cfg;

  logic                    f_valid, f_ready;
  logic signed [NUM_W-1:0] f_nn;
  logic [MAG_W-1:0]        f_dd;
  side_t                   f_side;

  logic                    c_valid [QUOT_BITS+1];
  logic                    c_ready [QUOT_BITS+1];
  logic [REM_W-1:0]        c_rem   [QUOT_BITS+1];
  logic [REM_W-1:0]        c_div   [QUOT_BITS+1];
  logic [QUOT_BITS-1:0]    c_quot  [QUOT_BITS+1];
  side_t                   c_side  [QUOT_BITS+1];

  logic                    last_ready;
  logic [LEVEL_W-1:0]      level_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_low   <= '0;
      cfg.window_high  <= SAMPLE_BITS'(255);
      cfg.view_mode    <= VIEW_DIRECT;
      cfg.above_policy <= POL_FULL;
      cfg.below_policy <= POL_ZERO;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LOW:   cfg.window_low   <= cfg_data;
        REG_WINDOW_HIGH:  cfg.window_high  <= cfg_data;
        REG_VIEW_MODE:    cfg.view_mode    <= cfg_data[1:0];
        REG_ABOVE_POLICY: cfg.above_policy <= cfg_data[1:0];
        REG_BELOW_POLICY: cfg.below_policy <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  iwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .center    (s_tdata[SAMPLE_BITS-1:0]),
    .prior     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .following (s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .present   (s_tuser),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_nn    (f_nn),
    .out_dd    (f_dd),
    .out_side  (f_side)
  );

  iwm_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_nn     (f_nn),
    .in_dd     (f_dd),
    .in_side   (f_side),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_rem   (c_rem[0]),
    .out_div   (c_div[0]),
    .out_side  (c_side[0])
  );

  assign c_quot[0] = '0;

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
    iwm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_rem    (c_rem[i]),
      .in_div    (c_div[i]),
      .in_quot   (c_quot[i]),
      .in_side   (c_side[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_div   (c_div[i+1]),
      .out_quot  (c_quot[i+1]),
      .out_side  (c_side[i+1])
    );
  end

  assign last_ready           = !m_tvalid || m_tready;
  assign c_ready[QUOT_BITS]   = last_ready;

  // quotient of 256 or more saturates
  always_comb begin
    if (c_side[QUOT_BITS].forced) begin
      level_next = c_side[QUOT_BITS].level;
    end else if (|c_quot[QUOT_BITS][QUOT_BITS-1:LEVEL_W]) begin
      level_next = LEVEL_MAX;
    end else begin
      level_next = c_quot[QUOT_BITS][LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (last_ready) begin
      m_tvalid <= c_valid[QUOT_BITS];
    end
    if (last_ready && c_valid[QUOT_BITS]) begin
      m_tdata <= level_next;
      m_tuser <= c_side[QUOT_BITS].empty;
    end
  end

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == LEVEL_ZERO)
    else $error("empty window result with nonzero level");

  a_drained_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("result valid right after reset");

  a_forced_divider_free: assert property (@(posedge clk) disable iff (rst)
    c_valid[QUOT_BITS] && c_side[QUOT_BITS].empty |-> c_side[QUOT_BITS].forced)
    else $error("empty window reached output without forced level");

endmodule
